// File: rtl/hdcc_pkg.sv
// Shared types, constants and helpers for the HSV dominant colour classifier.
// No dependencies; used by the top level and its checker.
package hdcc_pkg;

	// Field widths
	localparam int unsigned CH_W    = 8;
	localparam int unsigned CNT_W   = 21;
	localparam int unsigned RANGE_W = 48;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned S_TDATA_W = 24;
	localparam int unsigned M_TDATA_W = 72;

	// Counter ceiling: lesser of the frame size limit and the counter range
	localparam int unsigned MAX_FRAME_PIXELS = 1048576;
	localparam int unsigned CNT_FULL = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] CNT_CAP =
		CNT_W'((MAX_FRAME_PIXELS < CNT_FULL) ? MAX_FRAME_PIXELS : CNT_FULL);

	// Result colour codes
	typedef enum logic [1:0] {
		COLOR_UNKNOWN = 2'd0,
		COLOR_RED     = 2'd1,
		COLOR_YELLOW  = 2'd2,
		COLOR_GREEN   = 2'd3
	} color_t;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_RED_LOW  = 2'd0,
		REG_RED_HIGH = 2'd1,
		REG_YELLOW   = 2'd2,
		REG_GREEN    = 2'd3
	} reg_idx_t;

	// Box register, h_min in the lowest byte
	typedef struct packed {
		logic [CH_W-1:0] v_max;
		logic [CH_W-1:0] s_max;
		logic [CH_W-1:0] h_max;
		logic [CH_W-1:0] v_min;
		logic [CH_W-1:0] s_min;
		logic [CH_W-1:0] h_min;
	} box_t;

	// Reset boxes
	localparam box_t RED_LOW_RST  = 48'hFFFF0A646400;
	localparam box_t RED_HIGH_RST = 48'hFFFFB46464A0;
	localparam box_t YELLOW_RST   = 48'hFFFF28646414;
	localparam box_t GREEN_RST    = 48'hFFFF50646432;

	// Pixel as it arrives on the input word
	typedef struct packed {
		logic [CH_W-1:0] brightness;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] hue;
	} pixel_t;

	// Result word, colour code in the lowest bits
	typedef struct packed {
		logic [6:0]       pad;
		logic [CNT_W-1:0] green_total;
		logic [CNT_W-1:0] yellow_total;
		logic [CNT_W-1:0] red_total;
		color_t           color_code;
	} result_t;

	// Inclusive box test; an inverted box matches nothing
	function automatic logic in_box(input box_t b, input pixel_t p);
		in_box = (p.hue >= b.h_min) && (p.saturation >= b.s_min) &&
			(p.brightness >= b.v_min) && (p.hue <= b.h_max) &&
			(p.saturation <= b.s_max) && (p.brightness <= b.v_max);
	endfunction

	// Saturating increment
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		bump = (c < CNT_CAP) ? c + CNT_W'(1) : CNT_CAP;
	endfunction

endpackage

// File: rtl/hsv_dominant_color_classifier_unit.sv
// Top level of the HSV dominant colour classifier: box tests, counters, result stage.
// Depends on hdcc_pkg.
//
// Usage:
//   Pixels enter on the s_ stream: one word per pixel, s_tlast marks the
//   last pixel of a frame. Each pixel is tested against two red boxes, a
//   yellow box and a green box; matches bump saturating 21-bit counters.
//   After the last pixel one result word leaves on the m_ stream: the
//   winning colour (strictly greatest count, else unknown) and the three
//   totals; the counters then restart from zero for the next frame. The user must
//   write boxes through cfg_we/cfg_idx/cfg_data only while the block idles; unenforced.
// Throughput and result path:
//   One pixel per cycle sustained while s_tready is high. The last pixel of a frame
//   and then its result pass the input register, box-test register, totals register
//   and output register; the result word shows on m_tvalid from the output register.
// Reset:
//   arst_n clears all valid flags and counters and loads the default boxes.
// Stall:
//   When m_tready is low the result holds; pixels keep flowing until a frame
//   end waits in the box-test stage behind results held in the totals and
//   output stages, then s_tready drops once the input register is full too.
module hsv_dominant_color_classifier_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// cfg: register write port
	input  logic                                cfg_we,
	input  logic [hdcc_pkg::IDX_W-1:0]          cfg_idx,
	input  logic [hdcc_pkg::RANGE_W-1:0]        cfg_data,
	// pixel stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hdcc_pkg::S_TDATA_W-1:0]      s_tdata,   // hue, saturation, brightness
	input  logic                                s_tlast,   // last_pixel
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hdcc_pkg::M_TDATA_W-1:0]      m_tdata    // color_code, red_total,
	                                                       // yellow_total, green_total, zero pad
);

	// Box registers
	hdcc_pkg::box_t red_low_q, red_high_q, yellow_q, green_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_low_q  <= hdcc_pkg::RED_LOW_RST;
			red_high_q <= hdcc_pkg::RED_HIGH_RST;
			yellow_q   <= hdcc_pkg::YELLOW_RST;
			green_q    <= hdcc_pkg::GREEN_RST;
		end else if (cfg_we) begin
			unique case (hdcc_pkg::reg_idx_t'(cfg_idx))
				hdcc_pkg::REG_RED_LOW:  red_low_q  <= cfg_data;
				hdcc_pkg::REG_RED_HIGH: red_high_q <= cfg_data;
				hdcc_pkg::REG_YELLOW:   yellow_q   <= cfg_data;
				hdcc_pkg::REG_GREEN:    green_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage flags and handshake chain
	logic valid_s1, last_s1;
	hdcc_pkg::pixel_t pix_s1;
	logic valid_s2, last_s2, red_hit_s2, yellow_hit_s2, green_hit_s2;
	logic valid_s3;
	logic [hdcc_pkg::CNT_W-1:0] red_s3, yellow_s3, green_s3;
	logic out_valid_q;
	hdcc_pkg::result_t out_q;

	logic out_free, s3_free, s2_move, s2_free, s1_free;

	assign out_free = !out_valid_q || m_tready;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_move  = valid_s2 && (!last_s2 || s3_free);
	assign s2_free  = !valid_s2 || s2_move;
	assign s1_free  = !valid_s1 || s2_free;
	assign s_tready = s1_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && s_tvalid) begin
			pix_s1  <= hdcc_pkg::pixel_t'(s_tdata);
			last_s1 <= s_tlast;
		end
	end

	// Box tests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			last_s2       <= last_s1;
			red_hit_s2    <= hdcc_pkg::in_box(red_low_q, pix_s1) ||
				hdcc_pkg::in_box(red_high_q, pix_s1);
			yellow_hit_s2 <= hdcc_pkg::in_box(yellow_q, pix_s1);
			green_hit_s2  <= hdcc_pkg::in_box(green_q, pix_s1);
		end
	end

	// Counters; frame end hands the totals on and restarts them
	logic [hdcc_pkg::CNT_W-1:0] red_cnt_q, yellow_cnt_q, green_cnt_q;
	logic [hdcc_pkg::CNT_W-1:0] red_nxt, yellow_nxt, green_nxt;

	assign red_nxt    = red_hit_s2    ? hdcc_pkg::bump(red_cnt_q)    : red_cnt_q;
	assign yellow_nxt = yellow_hit_s2 ? hdcc_pkg::bump(yellow_cnt_q) : yellow_cnt_q;
	assign green_nxt  = green_hit_s2  ? hdcc_pkg::bump(green_cnt_q)  : green_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_cnt_q    <= '0;
			yellow_cnt_q <= '0;
			green_cnt_q  <= '0;
		end else if (s2_move) begin
			if (last_s2) begin
				red_cnt_q    <= '0;
				yellow_cnt_q <= '0;
				green_cnt_q  <= '0;
			end else begin
				red_cnt_q    <= red_nxt;
				yellow_cnt_q <= yellow_nxt;
				green_cnt_q  <= green_nxt;
			end
		end
	end

	// Totals stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= s2_move && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && s2_move && last_s2) begin
			red_s3    <= red_nxt;
			yellow_s3 <= yellow_nxt;
			green_s3  <= green_nxt;
		end
	end

	// Winner: strictly greatest count, else unknown
	hdcc_pkg::color_t code;

	always_comb begin
		priority if (red_s3 > yellow_s3 && red_s3 > green_s3)
			code = hdcc_pkg::COLOR_RED;
		else if (yellow_s3 > red_s3 && yellow_s3 > green_s3)
			code = hdcc_pkg::COLOR_YELLOW;
		else if (green_s3 > red_s3 && green_s3 > yellow_s3)
			code = hdcc_pkg::COLOR_GREEN;
		else
			code = hdcc_pkg::COLOR_UNKNOWN;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			out_q.pad          <= '0;
			out_q.color_code   <= code;
			out_q.red_total    <= red_s3;
			out_q.yellow_total <= yellow_s3;
			out_q.green_total  <= green_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// File: rtl/hdcc_checker.sv
// Port-level checker for the HSV dominant colour classifier, bound to the top level.
// Depends on hdcc_pkg and hsv_dominant_color_classifier_unit.
module hdcc_port_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [hdcc_pkg::M_TDATA_W-1:0]      m_tdata
);

	hdcc_pkg::result_t res;
	assign res = m_tdata;

	// Stalled result word stays offered and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed under stall");

	// Reported winner really has the strictly greatest count
	a_winner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		(res.color_code != hdcc_pkg::COLOR_RED ||
			(res.red_total > res.yellow_total && res.red_total > res.green_total)) &&
		(res.color_code != hdcc_pkg::COLOR_YELLOW ||
			(res.yellow_total > res.red_total && res.yellow_total > res.green_total)) &&
		(res.color_code != hdcc_pkg::COLOR_GREEN ||
			(res.green_total > res.red_total && res.green_total > res.yellow_total)))
		else $error("colour code disagrees with totals");

	// Unknown only when no count is strictly greatest
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.color_code == hdcc_pkg::COLOR_UNKNOWN |->
		!(res.red_total > res.yellow_total && res.red_total > res.green_total) &&
		!(res.yellow_total > res.red_total && res.yellow_total > res.green_total) &&
		!(res.green_total > res.red_total && res.green_total > res.yellow_total))
		else $error("unknown reported with a clear winner");

	// Totals never pass the ceiling, padding stays zero
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.red_total <= hdcc_pkg::CNT_CAP &&
		res.yellow_total <= hdcc_pkg::CNT_CAP && res.green_total <= hdcc_pkg::CNT_CAP &&
		res.pad == '0)
		else $error("total above ceiling or padding set");

endmodule

bind hsv_dominant_color_classifier_unit hdcc_port_checker u_hdcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: bench/hdcc_checker.sv
// Checker for the HSV dominant colour classifier: follows box writes and
// pixel words, predicts each frame result and compares it with the result stream.
// Depends on hdcc_pkg.
module hdcc_checker
	import hdcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_idx,
	input  logic [RANGE_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // hue, saturation, brightness
	input  logic                 s_tlast,   // last_pixel
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // color_code, red_total, yellow_total,
	                                        // green_total, zero pad
	output int                   fail_count,
	output int                   pending
);

	box_t             boxes [4];
	logic [CNT_W-1:0] red_cnt;
	logic [CNT_W-1:0] yellow_cnt;
	logic [CNT_W-1:0] green_cnt;
	result_t          frame_results_q [$];
	int               errors;

	// Pixel inside a box on all three channels; a box with min above max misses
	function automatic logic covers(box_t b, pixel_t p);
		logic [23:0] px;
		logic [23:0] lo;
		logic [23:0] hi;
		px = p;
		lo = b[23:0];
		hi = b[47:24];
		for (int c = 0; c < 3; c++) begin
			if (px[8*c +: 8] < lo[8*c +: 8] || px[8*c +: 8] > hi[8*c +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Count up, holding at the ceiling
	function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
		return (c >= CNT_CAP) ? CNT_CAP : c + 1'b1;
	endfunction

	// Strictly greatest count wins, anything else is unknown
	function automatic color_t dominant(logic [CNT_W-1:0] r, logic [CNT_W-1:0] y,
			logic [CNT_W-1:0] g);
		if (r > y && r > g)
			return COLOR_RED;
		if (y > r && y > g)
			return COLOR_YELLOW;
		if (g > r && g > y)
			return COLOR_GREEN;
		return COLOR_UNKNOWN;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Accepted pixel: bump counters, close the frame on last
	task automatic take_pixel(pixel_t p, logic last);
		result_t r;
		if (covers(boxes[REG_RED_LOW], p) || covers(boxes[REG_RED_HIGH], p))
			red_cnt = count_up(red_cnt);
		if (covers(boxes[REG_YELLOW], p))
			yellow_cnt = count_up(yellow_cnt);
		if (covers(boxes[REG_GREEN], p))
			green_cnt = count_up(green_cnt);
		if (last) begin
			r = '0;
			r.color_code = dominant(red_cnt, yellow_cnt, green_cnt);
			r.red_total = red_cnt;
			r.yellow_total = yellow_cnt;
			r.green_total = green_cnt;
			frame_results_q.push_back(r);
			red_cnt = '0;
			yellow_cnt = '0;
			green_cnt = '0;
		end
	endtask

	// Accepted result word against the oldest prediction
	task automatic check_result(result_t got);
		result_t want;
		if (frame_results_q.size() == 0) begin
			$display("%0t: unexpected result word, expected none actual %0h", $time, got);
			errors++;
		end else begin
			want = frame_results_q.pop_front();
			compare_field("color_code", want.color_code, got.color_code);
			compare_field("red_total", want.red_total, got.red_total);
			compare_field("yellow_total", want.yellow_total, got.yellow_total);
			compare_field("green_total", want.green_total, got.green_total);
		end
	endtask

	// Sample both channels and the write port at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boxes[REG_RED_LOW] = RED_LOW_RST;
			boxes[REG_RED_HIGH] = RED_HIGH_RST;
			boxes[REG_YELLOW] = YELLOW_RST;
			boxes[REG_GREEN] = GREEN_RST;
			red_cnt = '0;
			yellow_cnt = '0;
			green_cnt = '0;
			frame_results_q.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(result_t'(m_tdata));
			if (s_tvalid && s_tready)
				take_pixel(pixel_t'(s_tdata), s_tlast);
			if (cfg_we)
				boxes[cfg_idx] = box_t'(cfg_data);
			fail_count <= errors;
			pending <= frame_results_q.size();
		end
	end

endmodule

// File: bench/testbench.sv
// Top of the classifier bench: clock, reset, box writes, pixel frames and verdict.
// Depends on hdcc_pkg, hdcc_checker and hsv_dominant_color_classifier_unit.
module testbench;
	import hdcc_pkg::*;

	localparam box_t RESET_BOXES [4] = '{RED_LOW_RST, RED_HIGH_RST, YELLOW_RST, GREEN_RST};
	localparam box_t FULL_BOX = 48'hFFFFFF_000000;
	localparam int   PHASES = 8;
	localparam int   PHASE_PIXELS = 200;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [IDX_W-1:0]     cfg_idx = '0;
	logic [RANGE_W-1:0]   cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // hue, saturation, brightness
	logic                 s_tlast = 1'b0; // last_pixel
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // color_code, red_total, yellow_total,
	                                      // green_total, zero pad
	int                   fail_count;
	int                   pending;
	bit                   steady = 1'b0;
	box_t                 cur_box [4];

	hsv_dominant_color_classifier_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hdcc_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// Watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// Result side back-pressure, off during the steady stretch
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 21);
	end

	// Random value between two bounds, edges favoured; anything if the span is inverted
	function automatic logic [7:0] pick_between(logic [7:0] lo, logic [7:0] hi);
		int unsigned pick;
		pick = $urandom_range(99);
		if (lo > hi)
			return 8'($urandom_range(255, 0));
		if (pick < 10)
			return lo;
		if (pick < 20)
			return hi;
		return 8'($urandom_range(hi, lo));
	endfunction

	// Box setting for one phase: defaults, extremes, raw bits or ordered spans
	function automatic box_t random_box(int idx);
		int unsigned pick;
		logic [47:0] b;
		logic [7:0]  lo;
		logic [7:0]  hi;
		pick = $urandom_range(99);
		if (pick < 15)
			return RESET_BOXES[idx];
		if (pick < 25)
			return FULL_BOX;
		if (pick < 30)
			return '1;
		if (pick < 35)
			return '0;
		if (pick < 45)
			return 48'({$urandom, $urandom});
		for (int c = 0; c < 3; c++) begin
			lo = 8'($urandom_range(255, 0));
			hi = 8'($urandom_range(255, 0));
			if (lo > hi) begin
				b[8*c +: 8] = hi;
				b[24 + 8*c +: 8] = lo;
			end else begin
				b[8*c +: 8] = lo;
				b[24 + 8*c +: 8] = hi;
			end
		end
		return b;
	endfunction

	task automatic write_box(reg_idx_t idx, box_t b);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= b;
		cur_box[idx] = b;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One pixel word, after a random gap with junk on the bus unless steady is set
	task automatic send_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic last);
		while (!steady && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			s_tdata <= S_TDATA_W'($urandom);
			s_tlast <= 1'($urandom_range(1, 0));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {v, s, h};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly pixels aimed inside one of the current boxes, the rest anywhere
	task automatic send_random_pixel(logic last);
		pixel_t p;
		box_t   b;
		if ($urandom_range(99) < 75) begin
			b = cur_box[$urandom_range(3, 0)];
			p.hue = pick_between(b.h_min, b.h_max);
			p.saturation = pick_between(b.s_min, b.s_max);
			p.brightness = pick_between(b.v_min, b.v_max);
		end else begin
			p = 24'($urandom);
		end
		send_pixel(p.hue, p.saturation, p.brightness, last);
	endtask

	// Let every frame result out and the pipeline empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		int frame_len;
		int sent;
		cur_box = RESET_BOXES;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default boxes: red wins, box edges, both red boxes
		send_pixel(0, 100, 100, 0);
		send_pixel(10, 255, 255, 0);
		send_pixel(180, 100, 255, 0);
		send_pixel(160, 200, 150, 0);
		send_pixel(5, 99, 200, 0);
		send_pixel(30, 150, 150, 1);
		// yellow wins, just outside the hue and value bounds
		send_pixel(20, 100, 100, 0);
		send_pixel(40, 255, 255, 0);
		send_pixel(41, 200, 200, 0);
		send_pixel(19, 200, 200, 0);
		send_pixel(30, 200, 99, 1);
		// green wins, hue above 180 taken as is
		send_pixel(50, 100, 100, 0);
		send_pixel(80, 255, 255, 0);
		send_pixel(200, 200, 200, 0);
		send_pixel(255, 255, 255, 0);
		send_pixel(181, 200, 200, 1);
		// empty frame of one pixel: all counts zero
		send_pixel(0, 0, 0, 1);
		// red and green tie
		send_pixel(5, 150, 150, 0);
		send_pixel(60, 150, 150, 1);
		wait_idle();

		// Extreme boxes: full, all ones, all zeros, inverted hue span
		write_box(REG_RED_LOW, FULL_BOX);
		write_box(REG_RED_HIGH, '1);
		write_box(REG_YELLOW, '0);
		write_box(REG_GREEN, 48'hFFFF_32_6464_64);
		// pixels hitting several boxes at once
		send_pixel(0, 0, 0, 0);
		send_pixel(255, 255, 255, 1);
		wait_idle();

		// Random phases, each with its own box setting
		for (int phase = 0; phase < PHASES; phase++) begin
			steady = (phase == 3);
			for (int r = 0; r < 4; r++)
				write_box(reg_idx_t'(r), random_box(r));
			sent = 0;
			while (sent < PHASE_PIXELS) begin
				frame_len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40) :
					$urandom_range(30, 1);
				for (int i = 0; i < frame_len; i++)
					send_random_pixel(i == frame_len - 1);
				sent += frame_len;
			end
			wait_idle();
		end
		steady = 1'b0;

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
